[src/tib36_pkg.sv]
`timescale 1ns / 1ps

package tib36_pkg;

  // Sizing of the path buffer and of the digit stores.
  localparam int MAX_PATH_CHARS = 31;
  localparam int MAX_DIGITS     = 8;

  localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
  localparam int ND_W        = $clog2(MAX_DIGITS + 1);

  // Field and register widths.
  localparam int IDX_W     = 32;
  localparam int DIV_W     = 16;
  localparam int DEPTH_W   = 4;
  localparam int K_W       = 4;
  localparam int CHAR_W    = 7;
  localparam int DIGIT_W   = 6;
  localparam int TOTAL_W   = 8;
  localparam int DIV_CNT_W = $clog2(IDX_W);
  localparam int CFG_IDX_W = 2;

  // Division by 36 is a shift by two and a multiply by the reciprocal of 9.
  localparam logic [31:0] RECIP_9     = 32'd3817748708;
  localparam int          RECIP_SHIFT = 35;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TILES_PER_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILES_PER_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_DEPTH       = 2'd2;

  localparam logic [DIV_W-1:0]   TILES_PER_WIDTH_RST  = 16'd16;
  localparam logic [DIV_W-1:0]   TILES_PER_HEIGHT_RST = 16'd16;
  localparam logic [DEPTH_W-1:0] PATH_DEPTH_RST       = 4'd2;

  // ASCII codes used in the path.
  localparam logic [CHAR_W-1:0] ASCII_SLASH = 7'h2F;
  localparam logic [CHAR_W-1:0] ASCII_DOT   = 7'h2E;
  localparam logic [CHAR_W-1:0] ASCII_T     = 7'h74;
  localparam logic [CHAR_W-1:0] ASCII_I     = 7'h69;
  localparam logic [CHAR_W-1:0] ASCII_F     = 7'h66;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A     = 7'h41;
  localparam logic [CHAR_W-1:0] ASCII_NUL   = 7'h00;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIGIT,
    ST_CHECK,
    ST_E_SLASH0,
    ST_E_HCOL,
    ST_E_HROW,
    ST_E_LSLASH,
    ST_E_LCOL,
    ST_E_LROW,
    ST_E_DOT,
    ST_E_T,
    ST_E_I,
    ST_E_F,
    ST_E_ERR
  } state_e;

  typedef enum logic [2:0] {
    SEL_SLASH,
    SEL_COL,
    SEL_ROW,
    SEL_DOT,
    SEL_T,
    SEL_I,
    SEL_F,
    SEL_ERR
  } char_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      div_step;
    logic      dig_step;
    logic      k_load;
    logic      k_dec;
    logic      emit;
    char_sel_e sel;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
    logic dig_last;
    logic reject;
    logic k_is_depth;
    logic k_is_zero;
    logic depth_zero;
    logic out_free;
  } dp_status_t;

  // Base-36 digit to its ASCII character.
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < 6'd10) begin
      return ASCII_ZERO + dx;
    end
    return ASCII_A + dx - 7'd10;
  endfunction

endpackage

[src/tib36_ctrl.sv]
`timescale 1ns / 1ps

module tib36_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  tib36_pkg::dp_status_t  status_i,
  output tib36_pkg::ctrl_cmd_t   cmd_o
);
  import tib36_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.sel    = SEL_SLASH;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        cmd_o.dig_step = 1'b1;
        if (status_i.dig_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.reject) begin
          state_d = ST_E_ERR;
        end else begin
          cmd_o.k_load = 1'b1;
          state_d      = ST_E_SLASH0;
        end
      end
      ST_E_SLASH0: begin
        cmd_o.sel = SEL_SLASH;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_E_HCOL;
        end
      end
      ST_E_HCOL: begin
        cmd_o.sel = SEL_COL;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_E_HROW;
        end
      end
      ST_E_HROW: begin
        cmd_o.sel = SEL_ROW;
        if (status_i.out_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.k_dec = 1'b1;
          // The pair at index path_depth closes the high part.
          if (!status_i.k_is_depth) begin
            state_d = ST_E_HCOL;
          end else if (status_i.depth_zero) begin
            state_d = ST_E_DOT;
          end else begin
            state_d = ST_E_LSLASH;
          end
        end
      end
      ST_E_LSLASH: begin
        cmd_o.sel = SEL_SLASH;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_E_LCOL;
        end
      end
      ST_E_LCOL: begin
        cmd_o.sel = SEL_COL;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_E_LROW;
        end
      end
      ST_E_LROW: begin
        cmd_o.sel = SEL_ROW;
        if (status_i.out_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.k_dec = 1'b1;
          state_d     = status_i.k_is_zero ? ST_E_DOT : ST_E_LSLASH;
        end
      end
      ST_E_DOT: begin
        cmd_o.sel = SEL_DOT;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_E_T;
        end
      end
      ST_E_T: begin
        cmd_o.sel = SEL_T;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_E_I;
        end
      end
      ST_E_I: begin
        cmd_o.sel = SEL_I;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_E_F;
        end
      end
      ST_E_F: begin
        cmd_o.sel = SEL_F;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_E_ERR: begin
        cmd_o.sel = SEL_ERR;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[src/tib36_datapath.sv]
`timescale 1ns / 1ps

module tib36_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tib36_pkg::ctrl_cmd_t            cmd_i,
  output tib36_pkg::dp_status_t           status_o,
  input  logic [tib36_pkg::IDX_W-1:0]     tile_col_i,
  input  logic [tib36_pkg::IDX_W-1:0]     tile_row_i,
  input  logic [tib36_pkg::DIV_W-1:0]     tiles_per_width_i,
  input  logic [tib36_pkg::DIV_W-1:0]     tiles_per_height_i,
  input  logic [tib36_pkg::DEPTH_W-1:0]   path_depth_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tib36_pkg::CHAR_W-1:0]    char_code_o,
  output logic                            last_o,
  output logic                            error_o
);
  import tib36_pkg::*;

  // Working values: dividend and quotient, later the value being split into digits.
  logic [IDX_W-1:0]       x_val_q, y_val_q;
  logic [DIV_W-1:0]       x_rem_q, y_rem_q;
  logic [DIV_CNT_W-1:0]   div_cnt_q;
  logic [DIGIT_IDX_W-1:0] dig_cnt_q;
  logic [ND_W-1:0]        nd_q;
  logic                   neg_q;
  logic [K_W-1:0]         k_q;

  // Digit stores, least significant digit first.
  logic [DIGIT_W-1:0] col_digits_q [MAX_DIGITS];
  logic [DIGIT_W-1:0] row_digits_q [MAX_DIGITS];

  // Output register.
  logic              valid_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;
  logic              err_q;

  // A zero divisor acts as one.
  logic [DIV_W-1:0] dw, dh;
  assign dw = (tiles_per_width_i  == '0) ? DIV_W'(1) : tiles_per_width_i;
  assign dh = (tiles_per_height_i == '0) ? DIV_W'(1) : tiles_per_height_i;

  // One restoring division step for each coordinate.
  logic [DIV_W:0]   x_shift, y_shift;
  logic             x_ge, y_ge;
  logic [DIV_W-1:0] x_rem_nxt, y_rem_nxt;
  always_comb begin
    x_shift   = {x_rem_q, x_val_q[IDX_W-1]};
    y_shift   = {y_rem_q, y_val_q[IDX_W-1]};
    x_ge      = x_shift >= {1'b0, dw};
    y_ge      = y_shift >= {1'b0, dh};
    x_rem_nxt = x_ge ? DIV_W'(x_shift - {1'b0, dw}) : x_shift[DIV_W-1:0];
    y_rem_nxt = y_ge ? DIV_W'(y_shift - {1'b0, dh}) : y_shift[DIV_W-1:0];
  end

  // One base-36 digit step: quotient by reciprocal multiply, remainder by shift-subtract.
  logic [61:0]        x_prod, y_prod;
  logic [26:0]        x_quo36, y_quo36;
  logic [IDX_W-1:0]   x_rem36, y_rem36;
  always_comb begin
    x_prod  = 62'(x_val_q[IDX_W-1:2]) * 62'(RECIP_9);
    y_prod  = 62'(y_val_q[IDX_W-1:2]) * 62'(RECIP_9);
    x_quo36 = x_prod[61:RECIP_SHIFT];
    y_quo36 = y_prod[61:RECIP_SHIFT];
    x_rem36 = x_val_q - {x_quo36, 5'b0} - {3'b0, x_quo36, 2'b0};
    y_rem36 = y_val_q - {y_quo36, 5'b0} - {3'b0, y_quo36, 2'b0};
  end

  // Path length and the index of the first high pair.
  logic [ND_W-1:0]    high;
  logic [TOTAL_W-1:0] total;
  logic [K_W:0]       k_start;
  always_comb begin
    if (TOTAL_W'(nd_q) > TOTAL_W'(path_depth_i)) begin
      high = ND_W'(TOTAL_W'(nd_q) - TOTAL_W'(path_depth_i));
    end else begin
      high = ND_W'(1);
    end
    total   = TOTAL_W'(5) + (TOTAL_W'(high) << 1) + TOTAL_W'(path_depth_i) * TOTAL_W'(3);
    k_start = (K_W + 1)'(TOTAL_W'(path_depth_i) + TOTAL_W'(high) - TOTAL_W'(1));
  end

  // Control registers of the sequence.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
      dig_cnt_q <= '0;
      nd_q      <= '0;
      neg_q     <= 1'b0;
      k_q       <= '0;
    end else begin
      if (cmd_i.load) begin
        div_cnt_q <= '0;
        dig_cnt_q <= '0;
        nd_q      <= '0;
        neg_q     <= tile_col_i[IDX_W-1] | tile_row_i[IDX_W-1];
      end
      if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      if (cmd_i.dig_step) begin
        dig_cnt_q <= dig_cnt_q + DIGIT_IDX_W'(1);
        if (x_val_q != '0 || y_val_q != '0) begin
          nd_q <= ND_W'(dig_cnt_q) + ND_W'(1);
        end
      end
      if (cmd_i.k_load) begin
        k_q <= k_start[K_W-1:0];
      end else if (cmd_i.k_dec) begin
        k_q <= k_q - K_W'(1);
      end
    end
  end

  // Dividend, quotient and remainder registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_val_q <= tile_col_i;
      y_val_q <= tile_row_i;
      x_rem_q <= '0;
      y_rem_q <= '0;
    end else if (cmd_i.div_step) begin
      x_val_q <= {x_val_q[IDX_W-2:0], x_ge};
      y_val_q <= {y_val_q[IDX_W-2:0], y_ge};
      x_rem_q <= x_rem_nxt;
      y_rem_q <= y_rem_nxt;
    end else if (cmd_i.dig_step) begin
      x_val_q <= IDX_W'(x_quo36);
      y_val_q <= IDX_W'(y_quo36);
    end
  end

  // Digit store writes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.dig_step) begin
      col_digits_q[dig_cnt_q] <= x_rem36[DIGIT_W-1:0];
      row_digits_q[dig_cnt_q] <= y_rem36[DIGIT_W-1:0];
    end
  end

  // Digit reads; positions beyond the store read as zero.
  logic [DIGIT_W-1:0] col_digit, row_digit;
  always_comb begin
    col_digit = '0;
    row_digit = '0;
    if (int'(k_q) < MAX_DIGITS) begin
      col_digit = col_digits_q[k_q[DIGIT_IDX_W-1:0]];
      row_digit = row_digits_q[k_q[DIGIT_IDX_W-1:0]];
    end
  end

  // Character selection.
  logic [CHAR_W-1:0] char_nxt;
  always_comb begin
    case (cmd_i.sel)
      SEL_SLASH: char_nxt = ASCII_SLASH;
      SEL_COL:   char_nxt = digit_to_ascii(col_digit);
      SEL_ROW:   char_nxt = digit_to_ascii(row_digit);
      SEL_DOT:   char_nxt = ASCII_DOT;
      SEL_T:     char_nxt = ASCII_T;
      SEL_I:     char_nxt = ASCII_I;
      SEL_F:     char_nxt = ASCII_F;
      SEL_ERR:   char_nxt = ASCII_NUL;
      default:   char_nxt = ASCII_NUL;
    endcase
  end

  // Output register; it holds a result until the transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      char_q <= char_nxt;
      last_q <= (cmd_i.sel == SEL_F) || (cmd_i.sel == SEL_ERR);
      err_q  <= cmd_i.sel == SEL_ERR;
    end
  end

  assign out_valid_o = valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;
  assign error_o     = err_q;

  // Status toward the controller.
  always_comb begin
    status_o            = '0;
    status_o.div_last   = &div_cnt_q;
    status_o.dig_last   = dig_cnt_q == DIGIT_IDX_W'(MAX_DIGITS - 1);
    status_o.reject     = neg_q || (total > TOTAL_W'(MAX_PATH_CHARS));
    status_o.k_is_depth = k_q == K_W'(path_depth_i);
    status_o.k_is_zero  = k_q == '0;
    status_o.depth_zero = path_depth_i == '0;
    status_o.out_free   = !valid_q || out_ready_i;
  end

endmodule

[src/tile_index_base36_path_encoder.sv]
`timescale 1ns / 1ps

// Channel   Direction  Content
// s_axis    in         tdata: tile_col [31:0], tile_row [63:32]
// m_axis    out        tdata: char_code [6:0]; tlast: last; tuser: error
// cfg       in         write enable, register index, 16-bit write data
//
// An item is accepted, passes the bit-serial dividers, the base-36 digit stage and the
// path length check, then emits one path character per cycle (7 to 31 characters)
// while the output is not stalled; an error item emits a single error character.
// The input is taken only while the block is idle; a stalled output holds the
// sequencer. Reset clears control state and loads the register reset values.

module tile_index_base36_path_encoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [63:0]                         s_axis_tdata,   // tile_col, tile_row
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,   // char_code, zero pad
  output logic                                m_axis_tlast,
  output logic [0:0]                          m_axis_tuser,   // error
  input  logic                                cfg_we_i,
  input  logic [tib36_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tib36_pkg::DIV_W-1:0]         cfg_data_i
);
  import tib36_pkg::*;

  logic [DIV_W-1:0]   tiles_per_width_q, tiles_per_height_q;
  logic [DEPTH_W-1:0] path_depth_q;

  ctrl_cmd_t         cmd;
  dp_status_t        status;
  logic [CHAR_W-1:0] char_code;

  // Configuration registers; unused indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tiles_per_width_q  <= TILES_PER_WIDTH_RST;
      tiles_per_height_q <= TILES_PER_HEIGHT_RST;
      path_depth_q       <= PATH_DEPTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TILES_PER_WIDTH:  tiles_per_width_q  <= cfg_data_i;
        CFG_TILES_PER_HEIGHT: tiles_per_height_q <= cfg_data_i;
        CFG_PATH_DEPTH:       path_depth_q       <= cfg_data_i[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  tib36_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tib36_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .tile_col_i         (s_axis_tdata[31:0]),
    .tile_row_i         (s_axis_tdata[63:32]),
    .tiles_per_width_i  (tiles_per_width_q),
    .tiles_per_height_i (tiles_per_height_q),
    .path_depth_i       (path_depth_q),
    .out_valid_o        (m_axis_tvalid),
    .out_ready_i        (m_axis_tready),
    .char_code_o        (char_code),
    .last_o             (m_axis_tlast),
    .error_o            (m_axis_tuser[0])
  );

  assign m_axis_tdata = {1'b0, char_code};

endmodule
